>>> src/lprt_pkg.sv
package lprt_pkg;

  // Field widths
  localparam int PtW      = 32;
  localparam int RotW     = 16;
  localparam int IntW     = 16;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  // Pipeline depth, from input register to output register
  localparam int NumStg = 5;

  // Round to nearest on a Q.14 drop: add half an LSB, then floor
  localparam int RndSh   = 14;
  localparam int RndBias = 8192;

  // Intensity scaling: floor(n / 255) estimated as (n * 65793) >> 24
  localparam int Recip255 = 65793;
  localparam int IntenMax = 32768;

  // Register map
  typedef enum logic [CfgIdxW-1:0] {
    REG_ROT_W   = 3'd0,
    REG_ROT_X   = 3'd1,
    REG_ROT_Y   = 3'd2,
    REG_ROT_Z   = 3'd3,
    REG_SHIFT_X = 3'd4,
    REG_SHIFT_Y = 3'd5,
    REG_SHIFT_Z = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [RotW-1:0] rot_w;
    logic [RotW-1:0] rot_x;
    logic [RotW-1:0] rot_y;
    logic [RotW-1:0] rot_z;
    logic [PtW-1:0]  shift_x;
    logic [PtW-1:0]  shift_y;
    logic [PtW-1:0]  shift_z;
  } cfg_t;

endpackage

>>> src/lprt_in_if.sv
interface lprt_in_if import lprt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic signed [PtW-1:0] pt_x;
  logic signed [PtW-1:0] pt_y;
  logic signed [PtW-1:0] pt_z;
  logic [IntW-1:0]       pt_intensity;

  modport source (output valid, output pt_x, output pt_y, output pt_z,
                  output pt_intensity, input ready);
  modport sink   (input valid, input pt_x, input pt_y, input pt_z,
                  input pt_intensity, output ready);
endinterface

>>> src/lprt_out_if.sv
interface lprt_out_if import lprt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic signed [PtW-1:0] out_x;
  logic signed [PtW-1:0] out_y;
  logic signed [PtW-1:0] out_z;
  logic [IntW-1:0]       out_intensity;

  modport source (output valid, output out_x, output out_y, output out_z,
                  output out_intensity, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z,
                  input out_intensity, output ready);
endinterface

>>> src/lprt_regs.sv
module lprt_regs import lprt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  // Write one register per beat; unmapped indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{rot_w: RotW'(16384), default: '0};
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_ROT_W:   cfg_q.rot_w   <= cfg_data_i[RotW-1:0];
        REG_ROT_X:   cfg_q.rot_x   <= cfg_data_i[RotW-1:0];
        REG_ROT_Y:   cfg_q.rot_y   <= cfg_data_i[RotW-1:0];
        REG_ROT_Z:   cfg_q.rot_z   <= cfg_data_i[RotW-1:0];
        REG_SHIFT_X: cfg_q.shift_x <= cfg_data_i[PtW-1:0];
        REG_SHIFT_Y: cfg_q.shift_y <= cfg_data_i[PtW-1:0];
        REG_SHIFT_Z: cfg_q.shift_z <= cfg_data_i[PtW-1:0];
        default:     cfg_q         <= cfg_q;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/lidar_point_rigid_transform_top.sv
// Rigid transform of a LiDAR point stream: each Q16.16 point is rotated by the
// configured Q2.14 quaternion (v' = (w^2-|u|^2)v + 2(u.v)u + 2w(u x v), so a
// non-unit quaternion scales the result by |q|^2), offset by the mount shift,
// remapped to (-y, z, x) and saturated to 32 bits; intensity becomes
// min(in/65280, 1) in Q1.15. One point is taken every clock cycle unless output
// back-pressure fills the five-stage multiply/accumulate pipeline; a stall
// holds only the occupied stages, empty ones still fill, and nothing is lost.
// Write the registers only while no points are in flight.
module lidar_point_rigid_transform_top import lprt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  lprt_in_if.sink             point_i,
  lprt_out_if.source          point_o
);

  localparam int SW  = 20;  // rounded scalar term
  localparam int DW  = 36;  // rounded dot product
  localparam int CW  = 35;  // rounded cross product
  localparam int PW  = 48;  // u_i * v_j
  localparam int MW  = 52;  // stage-three products
  localparam int AW  = 55;  // rotation accumulator
  localparam int RW  = AW - RndSh;
  localparam int TW  = RW + 1;  // after shift add
  localparam int NW  = TW + 1;  // after negation
  localparam int SqW = 32;
  localparam int SsW = 34;
  localparam int DsW = 50;
  localparam int CsW = 49;
  localparam int NnW = IntW + 7;   // intensity * 128
  localparam int IpW = NnW + 17;   // times reciprocal
  localparam int RmW = 9;

  localparam logic signed [NW-1:0] SatHi = NW'(64'sd2147483647);
  localparam logic signed [NW-1:0] SatLo = NW'(-64'sd2147483648);

  function automatic logic [PtW-1:0] sat32(input logic signed [NW-1:0] a);
    logic [PtW-1:0] res;
    if (a > SatHi) begin
      res = SatHi[PtW-1:0];
    end else if (a < SatLo) begin
      res = SatLo[PtW-1:0];
    end else begin
      res = a[PtW-1:0];
    end
    return res;
  endfunction

  // Configuration
  cfg_t cfg;

  lprt_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  logic signed [RotW-1:0] qw;
  logic signed [RotW-1:0] qu [3];
  logic signed [PtW-1:0]  sh [3];

  assign qw    = cfg.rot_w;
  assign qu[0] = cfg.rot_x;
  assign qu[1] = cfg.rot_y;
  assign qu[2] = cfg.rot_z;
  assign sh[0] = cfg.shift_x;
  assign sh[1] = cfg.shift_y;
  assign sh[2] = cfg.shift_z;

  // Pipeline control: a stage advances when empty or when the next one moves
  logic vld_q [NumStg];
  logic adv   [NumStg];

  always_comb begin
    adv[NumStg-1] = !vld_q[NumStg-1] || point_o.ready;
    for (int k = NumStg - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumStg; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else begin
      if (adv[0]) begin
        vld_q[0] <= point_i.valid;
      end
      for (int k = 1; k < NumStg; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign point_i.ready = adv[0];
  assign point_o.valid = vld_q[NumStg-1];

  // Stage 1: squares of the quaternion, u_i * v_j products, intensity product
  logic signed [PtW-1:0] s1_v_q [3];
  logic signed [SqW-1:0] s1_ww_q, s1_xx_q, s1_yy_q, s1_zz_q;
  logic signed [PW-1:0]  s1_p_q [3][3];
  logic [NnW-1:0]        s1_n_q;
  logic [IpW-1:0]        s1_ip_q;
  logic signed [PtW-1:0] in_v [3];
  logic [NnW-1:0]        in_n;

  assign in_v[0] = point_i.pt_x;
  assign in_v[1] = point_i.pt_y;
  assign in_v[2] = point_i.pt_z;
  assign in_n    = {point_i.pt_intensity, 7'b0};

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      s1_ww_q <= qw * qw;
      s1_xx_q <= qu[0] * qu[0];
      s1_yy_q <= qu[1] * qu[1];
      s1_zz_q <= qu[2] * qu[2];
      for (int i = 0; i < 3; i++) begin
        s1_v_q[i] <= in_v[i];
        for (int j = 0; j < 3; j++) begin
          s1_p_q[i][j] <= qu[i] * in_v[j];
        end
      end
      s1_n_q  <= in_n;
      s1_ip_q <= IpW'(in_n) * IpW'(Recip255);
    end
  end

  // Stage 2: round scalar, dot and cross terms; estimate quotient by 255
  logic signed [SsW-1:0] s2_ssum;
  logic signed [DsW-1:0] s2_dsum;
  logic signed [CsW-1:0] s2_csum [3];
  logic [IntW-1:0]       s2_q0;
  logic [NnW:0]          s2_rem;

  always_comb begin
    s2_ssum    = s1_ww_q - s1_xx_q - s1_yy_q - s1_zz_q + RndBias;
    s2_dsum    = s1_p_q[0][0] + s1_p_q[1][1] + s1_p_q[2][2] + RndBias;
    s2_csum[0] = s1_p_q[1][2] - s1_p_q[2][1] + RndBias;
    s2_csum[1] = s1_p_q[2][0] - s1_p_q[0][2] + RndBias;
    s2_csum[2] = s1_p_q[0][1] - s1_p_q[1][0] + RndBias;
    s2_q0      = s1_ip_q[IpW-1:IpW-IntW];
    s2_rem     = {1'b0, s1_n_q} - ((NnW+1)'(s2_q0) * (NnW+1)'(255));
  end

  logic signed [SW-1:0]  s2_s_q;
  logic signed [DW-1:0]  s2_d_q;
  logic signed [CW-1:0]  s2_c_q [3];
  logic signed [PtW-1:0] s2_v_q [3];
  logic [IntW-1:0]       s2_q0_q;
  logic [RmW-1:0]        s2_rem_q;

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      s2_s_q <= s2_ssum[SsW-1:RndSh];
      s2_d_q <= s2_dsum[DsW-1:RndSh];
      for (int i = 0; i < 3; i++) begin
        s2_c_q[i] <= s2_csum[i][CsW-1:RndSh];
        s2_v_q[i] <= s1_v_q[i];
      end
      s2_q0_q  <= s2_q0;
      s2_rem_q <= s2_rem[RmW-1:0];
    end
  end

  // Stage 3: scale each term per axis; finish the intensity quotient
  logic signed [MW-1:0] s3_ms_q [3];
  logic signed [MW-1:0] s3_md_q [3];
  logic signed [MW-1:0] s3_mw_q [3];
  logic [IntW-1:0]      s3_int_q;
  logic [IntW-1:0]      s3_q;

  always_comb begin
    s3_q = s2_q0_q + ((s2_rem_q >= RmW'(255)) ? IntW'(1) : IntW'(0));
    if (s3_q > IntW'(IntenMax)) begin
      s3_q = IntW'(IntenMax);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      for (int i = 0; i < 3; i++) begin
        s3_ms_q[i] <= s2_s_q * s2_v_q[i];
        s3_md_q[i] <= s2_d_q * qu[i];
        s3_mw_q[i] <= qw * s2_c_q[i];
      end
      s3_int_q <= s3_q;
    end
  end

  // Stage 4: accumulate and round each rotated component
  logic signed [AW-1:0] s4_acc [3];
  logic signed [RW-1:0] s4_r_q [3];
  logic [IntW-1:0]      s4_int_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s4_acc[i] = s3_ms_q[i] + s3_md_q[i] + s3_md_q[i] + s3_mw_q[i] + s3_mw_q[i]
                  + RndBias;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      for (int i = 0; i < 3; i++) begin
        s4_r_q[i] <= s4_acc[i][AW-1:RndSh];
      end
      s4_int_q <= s3_int_q;
    end
  end

  // Stage 5: add the mount offset, remap axes, saturate into the output register
  logic signed [TW-1:0] s5_t [3];
  logic signed [NW-1:0] s5_ny;
  logic [PtW-1:0]       out_x_q, out_y_q, out_z_q;
  logic [IntW-1:0]      out_int_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s5_t[i] = s4_r_q[i] + sh[i];
    end
    s5_ny = -s5_t[1];
  end

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      out_x_q   <= sat32(s5_ny);
      out_y_q   <= sat32(NW'(s5_t[2]));
      out_z_q   <= sat32(NW'(s5_t[0]));
      out_int_q <= s4_int_q;
    end
  end

  assign point_o.out_x         = out_x_q;
  assign point_o.out_y         = out_y_q;
  assign point_o.out_z         = out_z_q;
  assign point_o.out_intensity = out_int_q;

endmodule

>>> tb/sv/tb_lidar_point_rigid_transform_top.sv
`timescale 1ns / 1ps

module tb_lidar_point_rigid_transform_top import lprt_pkg::*; ();

  localparam int ClkPeriod  = 10;
  localparam int CycleLimit = 300000;
  localparam int RandSets   = 13;
  localparam int SetPoints  = 50;

  localparam logic [PtW-1:0]     PtMax = 32'h7FFF_FFFF;
  localparam logic [PtW-1:0]     PtMin = 32'h8000_0000;
  localparam logic [PtW-1:0]     PtOne = 32'h0001_0000;
  localparam logic [PtW-1:0]     PtNeg = 32'hFFFF_FFFF;
  localparam longint             SatHi = 64'sh0000_0000_7FFF_FFFF;
  localparam longint             SatLo = -SatHi - 1;
  // Index past the register map; writes there must be dropped
  localparam logic [CfgIdxW-1:0] RegUnmapped = 3'd7;

  typedef struct packed {
    logic [PtW-1:0]  x;
    logic [PtW-1:0]  y;
    logic [PtW-1:0]  z;
    logic [IntW-1:0] inten;
  } lidar_pt_t;

  typedef struct {
    int unsigned cfg_sel;
    lidar_pt_t   pt;
    bit          known;
    lidar_pt_t   want;
  } dir_row_t;

  localparam cfg_t CfgReset = '{16'h4000, 16'h0, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0};

  // Directed settings: reset, all max, all min, mixed signs, 90 deg yaw with a mount offset
  cfg_t dir_cfgs [5] = '{
    CfgReset,
    '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, PtMax, PtMax, PtMax},
    '{16'h8000, 16'h8000, 16'h8000, 16'h8000, PtMin, PtMin, PtMin},
    '{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, PtMax, PtMin, PtMax},
    '{16'h2D41, 16'h0000, 16'h0000, 16'h2D41, 32'h0001_8000, 32'hFFFF_0000, 32'h0002_4000}
  };

  // Identity rows carry their answer; the rest go through the predictor
  dir_row_t dir_tab [24] = '{
    '{0, '{32'h0, 32'h0, 32'h0, 16'h0000}, 1'b1, '{32'h0, 32'h0, 32'h0, 16'h0000}},
    '{0, '{32'h1, 32'h1, 32'h1, 16'h0001}, 1'b1, '{PtNeg, 32'h1, 32'h1, 16'h0000}},
    '{0, '{PtMax, PtMin, PtMin, 16'hFFFF}, 1'b1, '{PtMax, PtMin, PtMax, 16'h8000}},
    '{0, '{PtMin, PtMax, PtMax, 16'hFF00}, 1'b1, '{32'h8000_0001, PtMax, PtMin, 16'h8000}},
    '{0, '{PtOne, 32'hFFFF_0000, 32'h0002_0000, 16'h7F80}, 1'b1,
         '{PtOne, 32'h0002_0000, PtOne, 16'h4000}},
    '{0, '{PtNeg, PtNeg, PtNeg, 16'h00FF}, 1'b1, '{32'h1, PtNeg, PtNeg, 16'h0080}},
    '{0, '{PtMax, PtMax, 32'h0, 16'hFEFF}, 1'b1, '{32'h8000_0001, 32'h0, PtMax, 16'h7FFF}},
    '{0, '{32'h0, 32'h0, PtNeg, 16'h8000}, 1'b1, '{32'h0, PtNeg, 32'h0, 16'd16448}},
    '{1, '{PtMax, PtMax, PtMax, 16'hFFFF}, 1'b0, '0},
    '{1, '{PtMin, PtMin, PtMin, 16'h0000}, 1'b0, '0},
    '{1, '{PtMax, PtMin, PtMax, 16'h5555}, 1'b0, '0},
    '{1, '{32'h0005_0000, 32'hFFFD_0000, 32'h0000_8000, 16'hAAAA}, 1'b0, '0},
    '{2, '{PtMax, PtMax, PtMax, 16'hFFFF}, 1'b0, '0},
    '{2, '{PtMin, PtMin, PtMin, 16'h0000}, 1'b0, '0},
    '{2, '{PtMax, PtMin, PtMax, 16'h5555}, 1'b0, '0},
    '{2, '{32'h0005_0000, 32'hFFFD_0000, 32'h0000_8000, 16'hAAAA}, 1'b0, '0},
    '{3, '{PtMax, PtMax, PtMax, 16'hFFFF}, 1'b0, '0},
    '{3, '{PtMin, PtMin, PtMin, 16'h0000}, 1'b0, '0},
    '{3, '{PtMax, PtMin, PtMax, 16'h5555}, 1'b0, '0},
    '{3, '{32'h0005_0000, 32'hFFFD_0000, 32'h0000_8000, 16'hAAAA}, 1'b0, '0},
    '{4, '{PtMax, PtMax, PtMax, 16'hFFFF}, 1'b0, '0},
    '{4, '{PtMin, PtMin, PtMin, 16'h0000}, 1'b0, '0},
    '{4, '{PtMax, PtMin, PtMax, 16'h5555}, 1'b0, '0},
    '{4, '{32'h0005_0000, 32'hFFFD_0000, 32'h0000_8000, 16'hAAAA}, 1'b0, '0}
  };

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  lprt_in_if  pt_in ();
  lprt_out_if pt_out ();

  lidar_point_rigid_transform_top dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .point_i    (pt_in),
    .point_o    (pt_out)
  );

  cfg_t      config_now = CfgReset;
  lidar_pt_t transformed_q [$];
  int        gap_pct    = 0;
  int        stall_pct  = 0;
  int        fail_count = 0;
  int        cycle_cnt  = 0;

  always #(ClkPeriod / 2) clk = ~clk;

  // Round a Q.14 drop to nearest, ties upward
  function automatic longint round_q14(longint v);
    return (v + RndBias) >>> RndSh;
  endfunction

  function automatic logic [PtW-1:0] sat_q16(longint v);
    if (v > SatHi) return PtMax;
    if (v < SatLo) return PtMin;
    return v[PtW-1:0];
  endfunction

  // Rotate by q, add the mount offset, remap to (-y, z, x) and scale intensity
  function automatic lidar_pt_t transform_point(cfg_t c, lidar_pt_t p);
    longint w, ux, uy, uz, vx, vy, vz, s, d, cx, cy, cz, rx, ry, rz, n;
    lidar_pt_t o;
    w  = longint'($signed(c.rot_w));
    ux = longint'($signed(c.rot_x));
    uy = longint'($signed(c.rot_y));
    uz = longint'($signed(c.rot_z));
    vx = longint'($signed(p.x));
    vy = longint'($signed(p.y));
    vz = longint'($signed(p.z));
    s  = round_q14(w * w - ux * ux - uy * uy - uz * uz);
    d  = round_q14(ux * vx + uy * vy + uz * vz);
    cx = round_q14(uy * vz - uz * vy);
    cy = round_q14(uz * vx - ux * vz);
    cz = round_q14(ux * vy - uy * vx);
    rx = round_q14(s * vx + 2 * d * ux + 2 * w * cx) + longint'($signed(c.shift_x));
    ry = round_q14(s * vy + 2 * d * uy + 2 * w * cy) + longint'($signed(c.shift_y));
    rz = round_q14(s * vz + 2 * d * uz + 2 * w * cz) + longint'($signed(c.shift_z));
    o.x = sat_q16(-ry);
    o.y = sat_q16(rz);
    o.z = sat_q16(rx);
    n = longint'(p.inten) * 128 / 255;
    o.inten = IntW'((n > IntenMax) ? longint'(IntenMax) : n);
    return o;
  endfunction

  // Mostly metre-scale coordinates, with full-range values and the extremes mixed in
  function automatic logic [PtW-1:0] rand_coord();
    case ($urandom_range(9))
      0:       return PtMax;
      1:       return PtMin;
      2, 3, 4: return $urandom;
      default: return PtW'(int'($urandom_range(33554431)) - 16777216);
    endcase
  endfunction

  // Half near-unit range, half anything the register holds
  function automatic logic [RotW-1:0] rand_rot();
    if ($urandom_range(1) == 0) return RotW'(int'($urandom_range(32768)) - 16384);
    return RotW'($urandom);
  endfunction

  function automatic void check_field(string name, logic [PtW-1:0] want, logic [PtW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s wrong, expected %h, got %h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  // Write every register, junk in the unused upper bits, plus one stray index
  task automatic load_regs(input cfg_t c);
    write_reg(REG_ROT_W, {16'($urandom), c.rot_w});
    write_reg(REG_ROT_X, {16'($urandom), c.rot_x});
    write_reg(REG_ROT_Y, {16'($urandom), c.rot_y});
    write_reg(REG_ROT_Z, {16'($urandom), c.rot_z});
    write_reg(REG_SHIFT_X, c.shift_x);
    write_reg(REG_SHIFT_Y, c.shift_y);
    write_reg(REG_SHIFT_Z, c.shift_z);
    write_reg(RegUnmapped, $urandom);
    cfg_we     <= 1'b0;
    config_now = c;
  endtask

  // Hold valid until the beat is taken, with random gaps ahead of it
  task automatic send_point(input lidar_pt_t p, input lidar_pt_t want);
    while ($urandom_range(99) < gap_pct) begin
      pt_in.valid <= 1'b0;
      @(posedge clk);
    end
    pt_in.valid        <= 1'b1;
    pt_in.pt_x         <= p.x;
    pt_in.pt_y         <= p.y;
    pt_in.pt_z         <= p.z;
    pt_in.pt_intensity <= p.inten;
    do @(posedge clk); while (!pt_in.ready);
    transformed_q = {transformed_q, want};
  endtask

  // Drop valid, wait for every result, then let the pipeline run dry
  task automatic settle_pipeline();
    pt_in.valid <= 1'b0;
    while (transformed_q.size() != 0) @(posedge clk);
    repeat (NumStg + 2) @(posedge clk);
  endtask

  // Check each result beat against the oldest expectation; pick next stall
  always @(posedge clk) begin
    if (rst_n) begin
      if (pt_out.valid && pt_out.ready) begin
        if (transformed_q.size() == 0) begin
          $display("%0t: beat with nothing expected, got %h %h %h %h", $time,
                   pt_out.out_x, pt_out.out_y, pt_out.out_z, pt_out.out_intensity);
          fail_count++;
        end else begin
          lidar_pt_t want;
          want = transformed_q.pop_front();
          check_field("out_x", want.x, pt_out.out_x);
          check_field("out_y", want.y, pt_out.out_y);
          check_field("out_z", want.z, pt_out.out_z);
          check_field("out_intensity", PtW'(want.inten), PtW'(pt_out.out_intensity));
        end
      end
      pt_out.ready <= ($urandom_range(99) >= stall_pct);
    end else begin
      pt_out.ready <= 1'b0;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    cfg_t        rc;
    int unsigned cur_sel;
    lidar_pt_t   p;
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_idx            <= '0;
    cfg_data           <= '0;
    pt_in.valid        <= 1'b0;
    pt_in.pt_x         <= '0;
    pt_in.pt_y         <= '0;
    pt_in.pt_z         <= '0;
    pt_in.pt_intensity <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: reset values first, then the extreme settings and the yaw case
    cur_sel = 0;
    foreach (dir_tab[k]) begin
      if (dir_tab[k].cfg_sel != cur_sel) begin
        settle_pipeline();
        cur_sel = dir_tab[k].cfg_sel;
        load_regs(dir_cfgs[cur_sel]);
      end
      send_point(dir_tab[k].pt,
                 dir_tab[k].known ? dir_tab[k].want : transform_point(config_now, dir_tab[k].pt));
    end

    // Random settings and points; receiver-heavy stalls, then sender-heavy gaps, then none
    for (int set = 0; set < RandSets; set++) begin
      settle_pipeline();
      if (set < 5) begin
        gap_pct   = 22;
        stall_pct = 66;
      end else if (set < 9) begin
        gap_pct   = 66;
        stall_pct = 22;
      end else begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      rc.rot_w   = rand_rot();
      rc.rot_x   = rand_rot();
      rc.rot_y   = rand_rot();
      rc.rot_z   = rand_rot();
      rc.shift_x = rand_coord();
      rc.shift_y = rand_coord();
      rc.shift_z = rand_coord();
      load_regs(rc);
      repeat (SetPoints) begin
        p.x     = rand_coord();
        p.y     = rand_coord();
        p.z     = rand_coord();
        p.inten = IntW'($urandom);
        send_point(p, transform_point(config_now, p));
      end
    end

    settle_pipeline();
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
